FILE: hdl/tsrc_pkg.sv
// Shared types, codes and helpers for the thermostat setpoint/relay controller.
// No dependencies; every other file but tsrc_checker imports this package.
`timescale 1ns / 1ps

package tsrc_pkg;

	// event codes carried in tuser
	localparam logic [2:0] CMD_SAMPLE = 3'd0;
	localparam logic [2:0] CMD_RAISE  = 3'd1;
	localparam logic [2:0] CMD_LOWER  = 3'd2;
	localparam logic [2:0] CMD_ONOFF  = 3'd3;
	localparam logic [2:0] CMD_REMOTE = 3'd4;
	localparam logic [2:0] CMD_TICK   = 3'd5;

	// configuration register indexes
	localparam logic [2:0] REG_ADC_OFFSET      = 3'd0;
	localparam logic [2:0] REG_SETPOINT_MIN    = 3'd1;
	localparam logic [2:0] REG_SETPOINT_MAX    = 3'd2;
	localparam logic [2:0] REG_SETPOINT_STEP   = 3'd3;
	localparam logic [2:0] REG_HOLD_TICKS      = 3'd4;
	localparam logic [2:0] REG_REPORT_TICKS    = 3'd5;
	localparam logic [2:0] REG_BACKLIGHT_TICKS = 3'd6;

	localparam int CFG_DATA_W = 16;

	// largest value the packet can show, 255.9 degrees
	localparam logic [11:0] PKT_MAX_TENTHS = 12'd2559;

	// reciprocal constants: floor(m/39) = (m*1681)>>16 for m < 1024,
	// floor(x/10) = (x*3277)>>15 for x < 2560
	localparam logic [10:0] RECIP_39 = 11'd1681;
	localparam logic [11:0] RECIP_10 = 12'd3277;

	typedef struct packed {
		logic [9:0]  adc_offset;
		logic [11:0] setpoint_min;
		logic [11:0] setpoint_max;
		logic [6:0]  setpoint_step;
		logic [15:0] hold_ticks;
		logic [15:0] report_ticks;
		logic [15:0] backlight_ticks;
	} cfg_t;

	typedef struct packed {
		logic [2:0] command;
		logic [9:0] adc_sample;
		logic       remote_on;
		logic [7:0] remote_whole;
		logic [3:0] remote_tenths;
	} item_t;

	// result of the state update, packet values still binary tenths
	typedef struct packed {
		logic        relay_on;
		logic        backlight_on;
		logic        packet_valid;
		logic        enabled;
		logic [11:0] set_tenths;
		logic [11:0] temp_tenths;
	} upd_t;

	typedef struct packed {
		logic [7:0] whole;
		logic [3:0] tenth;
	} digits_t;

	// split tenths (0..2559) into whole degrees and tenths digit
	function automatic digits_t split_tenths(input logic [11:0] x);
		logic [23:0] prod;
		logic [7:0]  q;
		logic [11:0] rem;
		digits_t     d;
		prod    = x * RECIP_10;
		q       = prod[22:15];
		rem     = x - ({4'd0, q} * 12'd10);
		d.whole = q;
		d.tenth = rem[3:0];
		return d;
	endfunction

endpackage

FILE: hdl/tsrc_cfg.sv
// Configuration register file of the thermostat controller.
// Depends on tsrc_pkg for register indexes and the cfg_t bundle.
`timescale 1ns / 1ps

module tsrc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [2:0]                      cfg_index,
	input  logic [tsrc_pkg::CFG_DATA_W-1:0] cfg_data,
	output tsrc_pkg::cfg_t                  cfg
);
	import tsrc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.adc_offset      <= 10'd240;
			cfg_q.setpoint_min    <= 12'd100;
			cfg_q.setpoint_max    <= 12'd300;
			cfg_q.setpoint_step   <= 7'd5;
			cfg_q.hold_ticks      <= 16'd900;
			cfg_q.report_ticks    <= 16'd4500;
			cfg_q.backlight_ticks <= 16'd180;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ADC_OFFSET:      cfg_q.adc_offset      <= cfg_data[9:0];
				REG_SETPOINT_MIN:    cfg_q.setpoint_min    <= cfg_data[11:0];
				REG_SETPOINT_MAX:    cfg_q.setpoint_max    <= cfg_data[11:0];
				REG_SETPOINT_STEP:   cfg_q.setpoint_step   <= cfg_data[6:0];
				REG_HOLD_TICKS:      cfg_q.hold_ticks      <= cfg_data;
				REG_REPORT_TICKS:    cfg_q.report_ticks    <= cfg_data;
				REG_BACKLIGHT_TICKS: cfg_q.backlight_ticks <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/tsrc_core.sv
// Input register, controller state and combinational state update.
// Depends on tsrc_pkg; feeds an upd_t result into the output formatter.
`timescale 1ns / 1ps

module tsrc_core (
	input  logic            clk,
	input  logic            arst_n,
	input  tsrc_pkg::cfg_t  cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  tsrc_pkg::item_t in_item,
	output logic            upd_valid,
	input  logic            upd_ready,
	output tsrc_pkg::upd_t  upd
);
	import tsrc_pkg::*;

	logic        v_s1;
	item_t       item_s1;
	logic        v_s2;
	upd_t        upd_s2;
	logic        s1_adv;

	logic signed [11:0] temp_q;
	logic [11:0] sp_q;
	logic        en_q, relay_q, elapsed_q, bl_q;
	logic [15:0] hold_cnt_q, report_cnt_q, bl_cnt_q;

	// next-state values
	logic signed [11:0] temp_d;
	logic [11:0] sp_d;
	logic        en_d, relay_d, elapsed_d, bl_d, packet_d;
	logic [15:0] hold_cnt_d, report_cnt_d, bl_cnt_d;

	// sample conversion
	logic signed [10:0] diff;
	logic [10:0] diff_neg;
	logic [9:0]  mag;
	logic [20:0] prod39;
	logic [10:0] scaled;

	// key arithmetic
	logic [12:0] raise_sum, lower_lim;
	logic [11:0] remote_sp;
	logic [15:0] hold_inc, report_inc, bl_inc;
	logic        user_act, relay_a;

	function automatic logic follow(input logic signed [11:0] t, input logic [11:0] sp,
			input logic cur);
		logic signed [12:0] tx, sx;
		logic r;
		tx = {t[11], t};
		sx = {1'b0, sp};
		r  = cur;
		if (tx < sx)
			r = 1'b1;
		else if (tx > sx)
			r = 1'b0;
		return r;
	endfunction

	assign s1_adv   = v_s1 && (!v_s2 || upd_ready);
	assign in_ready = !v_s1 || s1_adv;

	// (adc - offset) * 40 / 39 toward zero = sign * (m + m/39)
	assign diff     = $signed({1'b0, item_s1.adc_sample}) - $signed({1'b0, cfg.adc_offset});
	assign diff_neg = -diff;
	assign mag      = diff[10] ? diff_neg[9:0] : diff[9:0];
	assign prod39   = mag * RECIP_39;
	assign scaled   = {1'b0, mag} + {6'd0, prod39[20:16]};

	assign raise_sum  = {1'b0, sp_q} + {6'd0, cfg.setpoint_step};
	assign lower_lim  = {1'b0, cfg.setpoint_min} + {6'd0, cfg.setpoint_step};
	assign remote_sp  = {item_s1.remote_whole, 3'd0} + {3'd0, item_s1.remote_whole, 1'b0}
		+ {8'd0, item_s1.remote_tenths};
	assign hold_inc   = hold_cnt_q + 16'd1;
	assign report_inc = report_cnt_q + 16'd1;
	assign bl_inc     = bl_cnt_q + 16'd1;

	always_comb begin
		temp_d       = temp_q;
		sp_d         = sp_q;
		en_d         = en_q;
		elapsed_d    = elapsed_q;
		bl_d         = bl_q;
		bl_cnt_d     = bl_cnt_q;
		hold_cnt_d   = hold_cnt_q;
		report_cnt_d = report_cnt_q;
		packet_d     = 1'b0;
		user_act     = 1'b0;
		case (item_s1.command)
			CMD_SAMPLE: begin
				temp_d = diff[10] ? -$signed({1'b0, scaled}) : $signed({1'b0, scaled});
			end
			CMD_RAISE: begin
				user_act = 1'b1;
				sp_d = (raise_sum > {1'b0, cfg.setpoint_max}) ? cfg.setpoint_max
					: raise_sum[11:0];
			end
			CMD_LOWER: begin
				user_act = 1'b1;
				sp_d = ({1'b0, sp_q} < lower_lim) ? cfg.setpoint_min
					: sp_q - {5'd0, cfg.setpoint_step};
			end
			CMD_ONOFF: begin
				user_act = 1'b1;
				en_d = !en_q;
			end
			CMD_REMOTE: begin
				user_act = 1'b1;
				en_d = item_s1.remote_on;
				sp_d = remote_sp;
			end
			CMD_TICK: begin
				hold_cnt_d = hold_inc;
				if (hold_inc >= cfg.hold_ticks) begin
					hold_cnt_d = 16'd0;
					elapsed_d  = 1'b1;
				end
				report_cnt_d = report_inc;
				if (report_inc >= cfg.report_ticks) begin
					report_cnt_d = 16'd0;
					packet_d     = 1'b1;
				end
				if (bl_q) begin
					bl_cnt_d = bl_inc;
					if (bl_inc >= cfg.backlight_ticks) begin
						bl_cnt_d = 16'd0;
						bl_d     = 1'b0;
					end
				end
			end
			default: ;
		endcase
		if (user_act) begin
			bl_d     = 1'b1;
			bl_cnt_d = 16'd0;
			packet_d = 1'b1;
		end
		// keys and remote updates act on the compare at once
		relay_a = relay_q;
		if (user_act)
			relay_a = en_d ? follow(temp_d, sp_d, relay_q) : 1'b0;
		// periodic re-evaluation once per hold interval
		relay_d = 1'b0;
		if (en_d) begin
			relay_d = relay_a;
			if (elapsed_d) begin
				elapsed_d = 1'b0;
				relay_d   = follow(temp_d, sp_d, relay_a);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			temp_q       <= '0;
			sp_q         <= 12'd200;
			en_q         <= 1'b1;
			relay_q      <= 1'b0;
			elapsed_q    <= 1'b1;
			hold_cnt_q   <= '0;
			report_cnt_q <= '0;
			bl_cnt_q     <= '0;
			bl_q         <= 1'b0;
		end else begin
			if (in_ready)
				v_s1 <= in_valid;
			if (s1_adv || upd_ready)
				v_s2 <= s1_adv;
			if (s1_adv) begin
				temp_q       <= temp_d;
				sp_q         <= sp_d;
				en_q         <= en_d;
				relay_q      <= relay_d;
				elapsed_q    <= elapsed_d;
				hold_cnt_q   <= hold_cnt_d;
				report_cnt_q <= report_cnt_d;
				bl_cnt_q     <= bl_cnt_d;
				bl_q         <= bl_d;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= in_item;
		if (s1_adv) begin
			upd_s2.relay_on     <= relay_d;
			upd_s2.backlight_on <= bl_d;
			upd_s2.packet_valid <= packet_d;
			upd_s2.enabled      <= en_d;
			upd_s2.set_tenths   <= !packet_d ? 12'd0
				: (sp_d > PKT_MAX_TENTHS) ? PKT_MAX_TENTHS : sp_d;
			// converted temperature never exceeds 104.9, so no upper clip
			upd_s2.temp_tenths  <= (packet_d && temp_d > 12'sd0) ? temp_d : 12'd0;
		end
	end

	assign upd_valid = v_s2;
	assign upd       = upd_s2;

endmodule

FILE: hdl/tsrc_fmt.sv
// Output stage: splits packet values into degree digits and holds the result item.
// Depends on tsrc_pkg for upd_t and split_tenths.
`timescale 1ns / 1ps

module tsrc_fmt (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           upd_valid,
	output logic           upd_ready,
	input  tsrc_pkg::upd_t upd,
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [31:0]    m_axis_tdata,
	output logic [0:0]     m_axis_tuser
);
	import tsrc_pkg::*;

	logic        out_valid_q;
	logic [31:0] tdata_q;
	logic        tuser_q;
	digits_t     sp_dig, tp_dig;

	assign upd_ready = !out_valid_q || m_axis_tready;
	assign sp_dig    = split_tenths(upd.set_tenths);
	assign tp_dig    = split_tenths(upd.temp_tenths);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (upd_ready)
			out_valid_q <= upd_valid;
	end

	always_ff @(posedge clk) begin
		if (upd_ready && upd_valid) begin
			tdata_q <= {5'd0, tp_dig.tenth, tp_dig.whole, sp_dig.tenth, sp_dig.whole,
				upd.enabled, upd.backlight_on, upd.relay_on};
			tuser_q <= upd.packet_valid;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = tdata_q;
	assign m_axis_tuser[0] = tuser_q;

endmodule

FILE: hdl/thermostat_setpoint_relay_controller.sv
// Thermostat with setpoint keys and on/off relay control under a minimum
// switching interval. One event item is accepted every clock cycle while the output
// is not held back; its result item passes the input register, the state update
// register and the digit formatting register, and every event passes through the
// combinational state update between the first two of these. Keys and remote
// updates act on the relay at once; otherwise the relay follows the temperature
// compare once per hold interval of ticks. Configuration writes take effect on
// the next cycle.
// Depends on tsrc_pkg, tsrc_cfg, tsrc_core and tsrc_fmt.
`timescale 1ns / 1ps

module thermostat_setpoint_relay_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// adc_sample[9:0], remote_on[10], remote_whole[18:11], remote_tenths[22:19]
	input  logic [23:0]                     s_axis_tdata,
	// command[2:0]
	input  logic [2:0]                      s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// relay_on[0], backlight_on[1], enabled[2], set_whole[10:3], set_tenth[14:11],
	// temp_whole[22:15], temp_tenth[26:23]
	output logic [31:0]                     m_axis_tdata,
	// packet_valid[0]
	output logic [0:0]                      m_axis_tuser,
	input  logic                            cfg_we,
	input  logic [2:0]                      cfg_index,
	input  logic [tsrc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tsrc_pkg::*;

	cfg_t  cfg;
	item_t in_item;
	upd_t  upd;
	logic  upd_valid, upd_ready;

	assign in_item.command       = s_axis_tuser;
	assign in_item.adc_sample    = s_axis_tdata[9:0];
	assign in_item.remote_on     = s_axis_tdata[10];
	assign in_item.remote_whole  = s_axis_tdata[18:11];
	assign in_item.remote_tenths = s_axis_tdata[22:19];

	tsrc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tsrc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (in_item),
		.upd_valid (upd_valid),
		.upd_ready (upd_ready),
		.upd       (upd)
	);

	tsrc_fmt u_fmt (
		.clk           (clk),
		.arst_n        (arst_n),
		.upd_valid     (upd_valid),
		.upd_ready     (upd_ready),
		.upd           (upd),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

FILE: hdl/tsrc_checker.sv
// Port-level checks for the thermostat controller, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module tsrc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	// hold a stalled result item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result item changed");

	// drop packet contents on items without a packet
	a_no_pkt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[26:3] == 24'd0)
		else $error("packet fields set without packet");

	a_tenth_digits: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[14:11] <= 4'd9 && m_axis_tdata[26:23] <= 4'd9)
		else $error("tenths digit out of range");

	// relay is forced off while disabled
	a_relay_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[2])
		else $error("relay on while disabled");

endmodule

bind thermostat_setpoint_relay_controller tsrc_checker u_tsrc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

FILE: sim/tb_thermostat_setpoint_relay_controller.sv
// Self-checking testbench for thermostat_setpoint_relay_controller: event items
// in, one status item out per event, compared against an in-bench predictor.
// Depends on tsrc_pkg and the controller RTL.
`timescale 1ns / 1ps

module tb_thermostat_setpoint_relay_controller;
	import tsrc_pkg::*;

	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;
	localparam int QUIET_LIMIT    = 3000;
	localparam int DRAIN_CYCLES   = 8;
	localparam int MAX_REPORTED   = 10;
	localparam int ITEMS_PER_PASS = 315;

	typedef struct packed {
		logic       relay_on;
		logic       backlight_on;
		logic       packet_valid;
		logic       enabled;
		logic [7:0] set_whole;
		logic [3:0] set_tenth;
		logic [7:0] temp_whole;
		logic [3:0] temp_tenth;
	} status_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor copy of the configuration
	logic [9:0]  cfg_adc_offset   = 10'd240;
	logic [11:0] cfg_setpoint_min = 12'd100;
	logic [11:0] cfg_setpoint_max = 12'd300;
	logic [6:0]  cfg_step         = 7'd5;
	logic [15:0] cfg_hold         = 16'd900;
	logic [15:0] cfg_report       = 16'd4500;
	logic [15:0] cfg_backlight    = 16'd180;

	// predictor copy of the controller state
	logic signed [11:0] temperature = '0;
	logic [11:0] setpoint     = 12'd200;
	logic        enabled_st   = 1'b1;
	logic        relay_st     = 1'b0;
	logic        hold_due     = 1'b1;
	logic [15:0] hold_count   = '0;
	logic [15:0] report_count = '0;
	logic [15:0] light_count  = '0;
	logic        backlight_st = 1'b0;

	item_t   event_queue[$];
	status_t expected_status[$];
	item_t   item_on_bus;
	int      send_idle_pct = 14;
	int      recv_idle_pct = 62;
	int      mismatches = 0;
	int      quiet_cycles = 0;

	thermostat_setpoint_relay_controller u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	function automatic void relay_follow();
		if (!enabled_st) begin
			relay_st = 1'b0;
		end else if (int'(temperature) < int'(setpoint)) begin
			relay_st = 1'b1;
		end else if (int'(temperature) > int'(setpoint)) begin
			relay_st = 1'b0;
		end
	endfunction

	function automatic status_t thermostat_step(input item_t it);
		status_t     r;
		int          acc;
		logic [11:0] shown;
		r = '0;
		if (it.command inside {CMD_RAISE, CMD_LOWER, CMD_ONOFF, CMD_REMOTE}) begin
			backlight_st = 1'b1;
			light_count  = '0;
			r.packet_valid = 1'b1;
		end
		case (it.command)
			CMD_SAMPLE: begin
				acc = int'(it.adc_sample) - int'(cfg_adc_offset);
				acc = (acc * 40) / 39;
				temperature = acc[11:0];
			end
			CMD_RAISE: begin
				acc = int'(setpoint) + int'(cfg_step);
				if (acc > int'(cfg_setpoint_max))
					acc = int'(cfg_setpoint_max);
				setpoint = acc[11:0];
				relay_follow();
			end
			CMD_LOWER: begin
				acc = int'(setpoint) - int'(cfg_step);
				if (acc < int'(cfg_setpoint_min))
					acc = int'(cfg_setpoint_min);
				setpoint = acc[11:0];
				relay_follow();
			end
			CMD_ONOFF: begin
				enabled_st = ~enabled_st;
				relay_follow();
			end
			CMD_REMOTE: begin
				enabled_st = it.remote_on;
				acc = int'(it.remote_whole) * 10 + int'(it.remote_tenths);
				setpoint = acc[11:0];
				relay_follow();
			end
			CMD_TICK: begin
				hold_count = hold_count + 16'd1;
				if (hold_count >= cfg_hold) begin
					hold_count = '0;
					hold_due   = 1'b1;
				end
				report_count = report_count + 16'd1;
				if (report_count >= cfg_report) begin
					report_count   = '0;
					r.packet_valid = 1'b1;
				end
				if (backlight_st) begin
					light_count = light_count + 16'd1;
					if (light_count >= cfg_backlight) begin
						light_count  = '0;
						backlight_st = 1'b0;
					end
				end
			end
			default: ;
		endcase
		// periodic re-evaluation follows every event
		if (enabled_st) begin
			if (hold_due) begin
				hold_due = 1'b0;
				relay_follow();
			end
		end else begin
			relay_st = 1'b0;
		end
		r.relay_on     = relay_st;
		r.backlight_on = backlight_st;
		r.enabled      = enabled_st;
		if (r.packet_valid) begin
			shown = (setpoint > PKT_MAX_TENTHS) ? PKT_MAX_TENTHS : setpoint;
			r.set_whole = 8'(shown / 10);
			r.set_tenth = 4'(shown % 10);
			if (temperature > 0) begin
				shown = (int'(temperature) > int'(PKT_MAX_TENTHS)) ? PKT_MAX_TENTHS
					: temperature;
				r.temp_whole = 8'(shown / 10);
				r.temp_tenth = 4'(shown % 10);
			end
		end
		return r;
	endfunction

	// driver: present queued event items, predict each one as it is accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_status.push_back(thermostat_step(item_on_bus));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (event_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					item_on_bus = event_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {1'b0, item_on_bus.remote_tenths, item_on_bus.remote_whole,
						item_on_bus.remote_on, item_on_bus.adc_sample};
					s_axis_tuser  <= item_on_bus.command;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each status item against the oldest prediction
	always @(posedge clk) begin
		status_t want;
		status_t got;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.relay_on     = m_axis_tdata[0];
				got.backlight_on = m_axis_tdata[1];
				got.enabled      = m_axis_tdata[2];
				got.set_whole    = m_axis_tdata[10:3];
				got.set_tenth    = m_axis_tdata[14:11];
				got.temp_whole   = m_axis_tdata[22:15];
				got.temp_tenth   = m_axis_tdata[26:23];
				got.packet_valid = m_axis_tuser[0];
				if (expected_status.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTED)
						$display("unexpected status item: %h", got);
				end else begin
					want = expected_status.pop_front();
					if (got.relay_on !== want.relay_on || got.backlight_on !== want.backlight_on ||
						got.packet_valid !== want.packet_valid || got.enabled !== want.enabled ||
						got.set_whole !== want.set_whole || got.set_tenth !== want.set_tenth ||
						got.temp_whole !== want.temp_whole || got.temp_tenth !== want.temp_tenth) begin
						mismatches++;
						if (mismatches <= MAX_REPORTED) begin
							$display("status mismatch: expected relay=%0d light=%0d pkt=%0d en=%0d",
								want.relay_on, want.backlight_on, want.packet_valid, want.enabled);
							$display("  expected set=%0d.%0d temp=%0d.%0d",
								want.set_whole, want.set_tenth, want.temp_whole, want.temp_tenth);
							$display("  got relay=%0d light=%0d pkt=%0d en=%0d",
								got.relay_on, got.backlight_on, got.packet_valid, got.enabled);
							$display("  got set=%0d.%0d temp=%0d.%0d",
								got.set_whole, got.set_tenth, got.temp_whole, got.temp_tenth);
						end
					end
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (event_queue.size() != 0 || s_axis_tvalid || expected_status.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_ADC_OFFSET:      cfg_adc_offset   = val[9:0];
			REG_SETPOINT_MIN:    cfg_setpoint_min = val[11:0];
			REG_SETPOINT_MAX:    cfg_setpoint_max = val[11:0];
			REG_SETPOINT_STEP:   cfg_step         = val[6:0];
			REG_HOLD_TICKS:      cfg_hold         = val;
			REG_REPORT_TICKS:    cfg_report       = val;
			REG_BACKLIGHT_TICKS: cfg_backlight    = val;
			default: ;
		endcase
	endtask

	// reconfigure only once everything in flight has come back
	task automatic configure(input int off, input int lo, input int hi, input int st,
		input int hold, input int rep, input int light);
		wait_drained();
		write_reg(REG_ADC_OFFSET, 16'(off));
		write_reg(REG_SETPOINT_MIN, 16'(lo));
		write_reg(REG_SETPOINT_MAX, 16'(hi));
		write_reg(REG_SETPOINT_STEP, 16'(st));
		write_reg(REG_HOLD_TICKS, 16'(hold));
		write_reg(REG_REPORT_TICKS, 16'(rep));
		write_reg(REG_BACKLIGHT_TICKS, 16'(light));
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic add_event(input logic [2:0] cmd, input int adc, input logic on,
		input int whole, input int tenths);
		item_t it;
		it.command       = cmd;
		it.adc_sample    = 10'(adc);
		it.remote_on     = on;
		it.remote_whole  = 8'(whole);
		it.remote_tenths = 4'(tenths);
		event_queue.push_back(it);
	endtask

	task automatic run_random(input int count);
		item_t it;
		int    pick;
		int    adc;
		for (int i = 0; i < count; i++) begin
			// keep the queue short so samples track the current setpoint
			while (event_queue.size() >= 4)
				@(negedge clk);
			it   = item_t'({$urandom, $urandom});
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				it.command = CMD_SAMPLE;
				if ($urandom_range(0, 2) == 0) begin
					adc = int'(cfg_adc_offset) + (int'(setpoint) * 39) / 40 + $urandom_range(0, 8) - 4;
					if (adc < 0)
						adc = 0;
					if (adc > 1023)
						adc = 1023;
					it.adc_sample = 10'(adc);
				end
			end else if (pick < 40) begin
				it.command = CMD_RAISE;
			end else if (pick < 50) begin
				it.command = CMD_LOWER;
			end else if (pick < 56) begin
				it.command = CMD_ONOFF;
			end else if (pick < 63) begin
				it.command = CMD_REMOTE;
				if ($urandom_range(0, 1) == 0)
					it.remote_whole = 8'($urandom_range(0, 110));
			end else if (pick < 97) begin
				it.command = CMD_TICK;
			end else begin
				it.command = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
			end
			event_queue.push_back(it);
		end
	endtask

	initial begin
		int lo;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: hold register zero, short report and backlight intervals
		configure(240, 100, 300, 5, 0, 2, 3);
		add_event(CMD_SAMPLE, 0, 1'b0, 0, 0);        // negative temperature
		add_event(CMD_RAISE, 1023, 1'b1, 255, 15);   // packet shows 0.0
		add_event(CMD_SAMPLE, 1023, 1'b1, 255, 15);
		add_event(CMD_LOWER, 0, 1'b0, 0, 0);
		add_event(CMD_REMOTE, 0, 1'b1, 255, 15);     // unclamped, saturates in packet
		add_event(CMD_RAISE, 0, 1'b0, 0, 0);         // clamped back to the max
		add_event(CMD_ONOFF, 0, 1'b0, 0, 0);         // disable, relay off
		add_event(CMD_TICK, 1023, 1'b1, 255, 15);
		add_event(CMD_TICK, 0, 1'b0, 0, 0);          // report while disabled
		add_event(CMD_SAMPLE, 300, 1'b0, 0, 0);
		add_event(CMD_ONOFF, 0, 1'b0, 0, 0);
		add_event(CMD_REMOTE, 1023, 1'b0, 0, 0);
		add_event(CMD_TICK, 0, 1'b0, 0, 0);
		add_event(CMD_TICK, 0, 1'b0, 0, 0);
		add_event(CMD_TICK, 0, 1'b0, 0, 0);          // backlight times out
		add_event(CMD_REMOTE, 0, 1'b1, 12, 9);
		add_event(CMD_LOWER, 0, 1'b0, 0, 0);
		add_event(CMD_LOWER, 0, 1'b0, 0, 0);         // steps down again, still above the min
		add_event(CMD_SPARE_LO, 1023, 1'b1, 255, 15);
		add_event(CMD_SPARE_HI, 0, 1'b0, 0, 0);
		add_event(CMD_SAMPLE, 240, 1'b0, 0, 0);      // zero degrees
		add_event(CMD_REMOTE, 0, 1'b1, 0, 0);        // equal compare keeps relay
		add_event(CMD_TICK, 0, 1'b0, 0, 0);

		configure(240, 100, 300, 5, 3, 5, 4);
		run_random(ITEMS_PER_PASS);
		configure(0, 0, 2559, 100, 1, 1, 1);
		run_random(ITEMS_PER_PASS);

		send_idle_pct = 62;
		recv_idle_pct = 14;
		configure(1023, 2559, 0, 1, 65535, 65535, 65535);  // min above max
		run_random(ITEMS_PER_PASS);
		lo = $urandom_range(0, 1500);
		configure($urandom_range(0, 1023), lo, $urandom_range(lo, 2559), $urandom_range(1, 100),
			$urandom_range(1, 20), $urandom_range(1, 20), $urandom_range(1, 20));
		run_random(ITEMS_PER_PASS);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		configure(512, 800, 200, 37, 0, 0, 0);
		run_random(ITEMS_PER_PASS);
		lo = $urandom_range(0, 1500);
		configure($urandom_range(0, 1023), lo, $urandom_range(lo, 2559), $urandom_range(1, 100),
			$urandom_range(1, 20), $urandom_range(1, 20), $urandom_range(1, 20));
		run_random(ITEMS_PER_PASS);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_status.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: thermostat_setpoint_relay_controller.f
hdl/tsrc_pkg.sv
hdl/tsrc_cfg.sv
hdl/tsrc_core.sv
hdl/tsrc_fmt.sv
hdl/thermostat_setpoint_relay_controller.sv
hdl/tsrc_checker.sv
sim/tb_thermostat_setpoint_relay_controller.sv
